### hw/rtl/mersenne_twister_generator_unit_defines.svh
// Assertion macros shared by the generator RTL.
`ifndef MERSENNE_TWISTER_GENERATOR_UNIT_DEFINES_SVH
`define MERSENNE_TWISTER_GENERATOR_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, checked at every rising edge outside reset.
`define MTG_ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("generator check failed");
// Next-cycle implication, checked at every rising edge outside reset.
`define MTG_ASSERT_NEXT(label, clk, rstn, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("generator check failed");
`else
`define MTG_ASSERT_IMPLIES(label, clk, rstn, ante, cons)
`define MTG_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

### hw/rtl/mtg_pkg.sv
// Types, constants and word functions of the MT19937 generator.
package mtg_pkg;

	typedef logic [31:0] word_t;

	localparam logic ACT_SEED = 1'b0;
	localparam logic ACT_DRAW = 1'b1;

	localparam word_t SEED_MULT    = 32'd1812433253;
	localparam word_t DEFAULT_SEED = 32'd5489;
	localparam word_t TWIST_XOR    = 32'h9908b0df;
	localparam word_t UPPER_MASK   = 32'h80000000;
	localparam word_t LOWER_MASK   = 32'h7fffffff;
	localparam word_t TEMPER_B     = 32'h9d2c5680;
	localparam word_t TEMPER_C     = 32'hefc60000;

	// Product term of the seeding recurrence, kept to the low 32 bits.
	function automatic word_t seed_product(input word_t prev);
		word_t folded;
		folded = prev ^ (prev >> 30);
		return SEED_MULT * folded;
	endfunction

	// One step of the twist: upper bit of a, lower bits of b, mixed into c.
	function automatic word_t mix_words(input word_t a, input word_t b, input word_t c);
		word_t y;
		word_t r;
		y = (a & UPPER_MASK) | (b & LOWER_MASK);
		r = c ^ (y >> 1);
		if (y[0]) begin
			r = r ^ TWIST_XOR;
		end
		return r;
	endfunction

	function automatic word_t temper(input word_t v);
		word_t y;
		y = v;
		y = y ^ (y >> 11);
		y = y ^ ((y << 7) & TEMPER_B);
		y = y ^ ((y << 15) & TEMPER_C);
		y = y ^ (y >> 18);
		return y;
	endfunction

endpackage

### hw/rtl/mtg_state_ram.sv
// State word memory: one write port and two registered read ports.
module mtg_state_ram #(
	parameter int DEPTH  = 624,
	parameter int ADDR_W = 10
) (
	input  logic                clk,
	input  logic                wr_en,
	input  logic [ADDR_W-1:0]   wr_addr,
	input  mtg_pkg::word_t      wr_data,
	input  logic [ADDR_W-1:0]   rd_a_addr,
	output mtg_pkg::word_t      rd_a_data,
	input  logic [ADDR_W-1:0]   rd_b_addr,
	output mtg_pkg::word_t      rd_b_data
);

	mtg_pkg::word_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_a_data <= mem[rd_a_addr];
		rd_b_data <= mem[rd_b_addr];
	end

endmodule

### hw/rtl/mersenne_twister_generator_unit.sv
// Top level of the MT19937 pseudo-random word generator.
// The generator keeps its 624 state words in a single-write, dual-read memory
// and works through them with one sequencer. A request with action seed writes
// the seed recurrence into the memory, one word per cycle, keeps the request
// side stalled until the last word is written and gives no result. A request
// with action draw, when unused words remain, goes through accept, memory read
// and tempering into the result register. When the words are used up, the
// draw first regenerates the whole state in place: after a read of word zero,
// each word takes one step to present the two memory reads and one to mix and
// write back, and this regeneration comes before every 624th draw. The very
// first draw after reset, when no seed was given, seeds with 5489 first and
// then regenerates the state before it reads its word. The result register
// lets the block take the next request while a finished word still waits on a
// stalled result side; a draw waits in its read cycle only while that register
// is full and stalled.
`include "mersenne_twister_generator_unit_defines.svh"
module mersenne_twister_generator_unit #(
	parameter int STATE_WORDS  = 624,
	parameter int SHIFT_OFFSET = 397
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  logic                action,
	input  mtg_pkg::word_t      seed_value,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output mtg_pkg::word_t      random_word
);

	localparam int ADDR_W = $clog2(STATE_WORDS);
	localparam int POS_W  = $clog2(STATE_WORDS + 2);

	// Read position codes: STATE_WORDS means used up, one more means unseeded.
	localparam logic [POS_W-1:0]  POS_USED     = POS_W'(STATE_WORDS);
	localparam logic [POS_W-1:0]  POS_UNSEEDED = POS_W'(STATE_WORDS + 1);
	localparam logic [ADDR_W-1:0] LAST_ADDR    = ADDR_W'(STATE_WORDS - 1);
	localparam logic [ADDR_W-1:0] FAR_START    = ADDR_W'(SHIFT_OFFSET);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SEED,
		S_TW_PRIME,
		S_TW_RD,
		S_TW_WR,
		S_DRAW_RD,
		S_DRAW_OUT
	} state_t;

	state_t              state_q;
	logic [POS_W-1:0]    pos_q;
	logic                draw_pend_q;
	logic                rsp_valid_q;

	logic [ADDR_W-1:0]   idx_q;
	logic [ADDR_W-1:0]   far_q;
	mtg_pkg::word_t      prev_q;
	mtg_pkg::word_t      cur_q;
	mtg_pkg::word_t      word_q;

	logic                req_accept;
	logic                idx_last;
	logic [ADDR_W-1:0]   nxt_addr;
	mtg_pkg::word_t      seed_word;
	mtg_pkg::word_t      twist_word;
	logic                draw_busy;
	logic                twist_done;

	logic                wr_en;
	logic [ADDR_W-1:0]   wr_addr;
	mtg_pkg::word_t      wr_data;
	logic [ADDR_W-1:0]   rd_a_addr;
	mtg_pkg::word_t      rd_a_data;
	mtg_pkg::word_t      rd_b_data;

	assign req_stall   = (state_q != S_IDLE);
	assign req_accept  = req_valid && !req_stall;
	assign rsp_valid   = rsp_valid_q;
	assign random_word = word_q;

	assign idx_last   = (idx_q == LAST_ADDR);
	assign nxt_addr   = idx_last ? '0 : idx_q + ADDR_W'(1);
	assign seed_word  = mtg_pkg::seed_product(prev_q) + 32'(idx_q);
	assign twist_word = mtg_pkg::mix_words(cur_q, rd_a_data, rd_b_data);
	assign draw_busy  = (state_q == S_DRAW_RD) || (state_q == S_DRAW_OUT);
	assign twist_done = (state_q == S_TW_WR) && idx_last;

	// Word zero of a seed is written at acceptance, from the request or the default;
	// the rest of the seed recurrence and the twist write at the running index.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = idx_q;
		wr_data = twist_word;
		case (state_q)
			S_IDLE: begin
				if (req_accept && (action == mtg_pkg::ACT_SEED || pos_q == POS_UNSEEDED)) begin
					wr_en   = 1'b1;
					wr_addr = '0;
					wr_data = (action == mtg_pkg::ACT_SEED) ? seed_value
						: mtg_pkg::DEFAULT_SEED;
				end
			end
			S_SEED: begin
				wr_en   = 1'b1;
				wr_data = seed_word;
			end
			S_TW_WR: begin
				wr_en = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Port A fetches the next word of the twist, word zero before the first
	// step, or the word to be drawn. Port B always fetches the far word.
	always_comb begin
		case (state_q)
			S_TW_PRIME: rd_a_addr = '0;
			S_DRAW_RD:  rd_a_addr = pos_q[ADDR_W-1:0];
			default:    rd_a_addr = nxt_addr;
		endcase
	end

	mtg_state_ram #(
		.DEPTH  (STATE_WORDS),
		.ADDR_W (ADDR_W)
	) u_state_ram (
		.clk       (clk),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_a_addr (rd_a_addr),
		.rd_a_data (rd_a_data),
		.rd_b_addr (far_q),
		.rd_b_data (rd_b_data)
	);

	// Sequencer state, read position, pending draw flag, result valid and the result word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pos_q       <= POS_UNSEEDED;
			draw_pend_q <= 1'b0;
			rsp_valid_q <= 1'b0;
			word_q      <= '0;
		end else begin
			// The result register is always empty when a new word is tempered.
			if (state_q == S_DRAW_OUT) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_accept) begin
						if (action == mtg_pkg::ACT_SEED) begin
							state_q     <= S_SEED;
							draw_pend_q <= 1'b0;
						end else if (pos_q == POS_UNSEEDED) begin
							state_q     <= S_SEED;
							draw_pend_q <= 1'b1;
						end else if (pos_q == POS_USED) begin
							state_q <= S_TW_PRIME;
						end else begin
							state_q <= S_DRAW_RD;
						end
					end
				end
				S_SEED: begin
					if (idx_last) begin
						pos_q   <= POS_USED;
						state_q <= draw_pend_q ? S_TW_PRIME : S_IDLE;
					end
				end
				S_TW_PRIME: begin
					state_q <= S_TW_RD;
				end
				S_TW_RD: begin
					state_q <= S_TW_WR;
				end
				S_TW_WR: begin
					if (idx_last) begin
						pos_q   <= '0;
						state_q <= S_DRAW_RD;
					end else begin
						state_q <= S_TW_RD;
					end
				end
				S_DRAW_RD: begin
					// Hold the read until the result register can take the word.
					if (!(rsp_valid_q && rsp_stall)) begin
						state_q <= S_DRAW_OUT;
					end
				end
				S_DRAW_OUT: begin
					word_q  <= mtg_pkg::temper(rd_a_data);
					pos_q   <= pos_q + POS_W'(1);
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath registers: running index, far index, seed chain and the
	// carried current word of the twist.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				far_q <= FAR_START;
				if (action == mtg_pkg::ACT_SEED || pos_q == POS_UNSEEDED) begin
					idx_q <= ADDR_W'(1);
				end else begin
					idx_q <= '0;
				end
				prev_q <= (action == mtg_pkg::ACT_SEED) ? seed_value
					: mtg_pkg::DEFAULT_SEED;
			end
			S_SEED: begin
				prev_q <= seed_word;
				idx_q  <= nxt_addr;
			end
			S_TW_RD: begin
				// Before the first step port A holds word zero.
				if (idx_q == '0) begin
					cur_q <= rd_a_data;
				end
			end
			S_TW_WR: begin
				// The next word just read is the current word of the next step.
				cur_q <= rd_a_data;
				idx_q <= nxt_addr;
				far_q <= (far_q == LAST_ADDR) ? '0 : far_q + ADDR_W'(1);
			end
			default: begin
			end
		endcase
	end

	`MTG_ASSERT_IMPLIES(a_pos_range, clk, arst_n, 1'b1, pos_q <= POS_UNSEEDED)
	`MTG_ASSERT_IMPLIES(a_slot_free, clk, arst_n, state_q == S_DRAW_OUT, !rsp_valid_q)
	`MTG_ASSERT_NEXT(a_draw_result, clk, arst_n, state_q == S_DRAW_OUT, rsp_valid_q)
	`MTG_ASSERT_IMPLIES(a_no_write_draw, clk, arst_n, draw_busy, !wr_en)
	`MTG_ASSERT_NEXT(a_twist_end, clk, arst_n, twist_done, state_q == S_DRAW_RD && pos_q == '0)

endmodule
